// ===== rtl/midi_to_cv_note_controller_defines.svh =====
// Assertion macros shared by the note controller RTL.
`ifndef MIDI_TO_CV_NOTE_CONTROLLER_DEFINES_SVH
`define MIDI_TO_CV_NOTE_CONTROLLER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MCV_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MCV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/mcv_pkg.sv =====
// Package with constants, codes and types for the note controller.
package mcv_pkg;
	localparam int STACK_DEPTH_DEF = 16;
	localparam logic [6:0] NOTE_MIN = 7'd36;
	localparam logic [6:0] NOTE_MAX = 7'd96;
	localparam logic [6:0] RETRIG_CC = 7'd68;
	localparam logic [7:0] AUX_TOP = 8'd239;

	localparam logic [3:0] M_BEND = 4'd0;
	localparam logic [3:0] M_CC = 4'd2;
	localparam logic [3:0] M_VEL = 4'd3;
	localparam logic [3:0] M_NOTE = 4'd4;
	localparam logic [3:0] M_INVNOTE = 4'd5;
	localparam logic [3:0] M_GATE = 4'd6;
	localparam logic [3:0] M_INVGATE = 4'd7;
	localparam logic [3:0] M_PARA = 4'd8;

	localparam logic [1:0] RT_OFF = 2'd0;
	localparam logic [1:0] RT_NEW = 2'd1;
	localparam logic [1:0] RT_EVERY = 2'd2;

	// Paraphonic priority modes.
	localparam logic [2:0] P_RECENT = 3'd0;
	localparam logic [2:0] P_RECENT_LOW = 3'd1;
	localparam logic [2:0] P_RECENT_HIGH = 3'd2;
	localparam logic [2:0] P_OUTER = 3'd3;
	localparam logic [2:0] P_HIGH = 3'd4;
	localparam logic [2:0] P_LOW = 3'd5;
	localparam logic [2:0] P_PEDAL = 3'd6;

	localparam logic [3:0] K_NOTE_OFF = 4'h8;
	localparam logic [3:0] K_NOTE_ON = 4'h9;
	localparam logic [3:0] K_CC = 4'hB;
	localparam logic [3:0] K_PROG = 4'hC;
	localparam logic [3:0] K_PRESS = 4'hD;
	localparam logic [3:0] K_BEND = 4'hE;

	localparam int REG_LISTEN = 0;
	localparam int REG_OMNI = 1;

	// Note operation handed from the byte decoder to the note engine.
	typedef struct packed {
		logic       start;
		logic       note_on;
		logic [5:0] note;
	} note_cmd_t;
endpackage

// ===== rtl/midi_to_cv_note_controller.sv =====
// Top level of the MIDI to CV note controller.
// Takes one MIDI byte per transaction and returns one result transaction with pitch, aux,
// gate and retrigger levels. A note message also waits on the note stack, which is
// searched, shifted and scanned one entry a cycle. The input stalls until the result has
// been handed on.
`include "midi_to_cv_note_controller_defines.svh"
module midi_to_cv_note_controller #(
	parameter int STACK_DEPTH = mcv_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pitch_level,
	output logic [7:0] aux_level,
	output logic       gate_level,
	output logic       retrigger_pulse
);
	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_WAIT = 2'd1;
	localparam logic [1:0] T_OUT = 2'd2;

	logic [1:0] tstate_q;
	logic [3:0] listen_q;
	logic       omni_q;
	logic [7:0] status_q;
	logic [1:0] phase_q;
	logic [6:0] first_q;
	logic [3:0] aux_mode_q;
	logic [2:0] prio_q;
	logic [1:0] retrig_q;
	logic [6:0] cc_q;
	logic       accept, busy, pulse_q, gate_q;
	logic [7:0] pitch_q, aux_q;
	logic [3:0] kind;
	logic       ch_ok;
	mcv_pkg::note_cmd_t cmd;
	logic       pitch_set, aux_set;
	logic [7:0] aux_val;
	logic [6:0] n_cl;
	logic       vel_q;
	logic [7:0] vel_val_q;
	logic       vel_apply;
	logic       eng_aux_set;
	logic [7:0] eng_aux_val;

	assign accept = in_valid && !in_stall;
	assign in_stall = (tstate_q != T_IDLE);
	assign kind = status_q[7:4];
	assign ch_ok = omni_q || (status_q[3:0] == listen_q);
	assign n_cl = (first_q < mcv_pkg::NOTE_MIN) ? mcv_pkg::NOTE_MIN :
		(first_q > mcv_pkg::NOTE_MAX) ? mcv_pkg::NOTE_MAX : first_q;

	// Second-data-byte decoding into note commands and aux updates.
	always_comb begin
		cmd = '0;
		aux_set = 1'b0;
		aux_val = {rx_byte[6:0], 1'b0};
		pitch_set = 1'b0;
		if (accept && rx_byte[7] == 1'b0 && status_q != 8'd0 && phase_q == 2'd2 && ch_ok) begin
			if (kind == mcv_pkg::K_NOTE_ON || kind == mcv_pkg::K_NOTE_OFF) begin
				cmd.start = 1'b1;
				cmd.note_on = (kind == mcv_pkg::K_NOTE_ON) && (rx_byte != 8'd0);
				cmd.note = 6'(n_cl - mcv_pkg::NOTE_MIN);
			end else if (kind == mcv_pkg::K_CC) begin
				aux_set = (first_q != mcv_pkg::RETRIG_CC) && (aux_mode_q == mcv_pkg::M_CC)
					&& (first_q == cc_q);
			end else if (kind == mcv_pkg::K_BEND) begin
				aux_set = (aux_mode_q == mcv_pkg::M_BEND);
			end
		end
	end

	// Velocity applies after the note engine finishes.
	assign vel_apply = (tstate_q == T_WAIT) && !busy && vel_q;
	assign eng_aux_set = aux_set || vel_apply;
	assign eng_aux_val = vel_apply ? vel_val_q : aux_val;

	mcv_note_engine #(.STACK_DEPTH(STACK_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .aux_mode(aux_mode_q),
		.priority_mode(prio_q), .retrig_mode(retrig_q),
		.pitch_set(pitch_set), .pitch_val(8'd0), .aux_set(eng_aux_set),
		.aux_val(eng_aux_val),
		.pulse_clr(accept), .busy(busy), .pitch_q(pitch_q), .aux_q(aux_q),
		.gate_q(gate_q), .pulse_q(pulse_q)
	);

	// Configuration, parser and transaction sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tstate_q <= T_IDLE;
			listen_q <= '0; omni_q <= 1'b0;
			status_q <= '0; phase_q <= '0; first_q <= '0;
			aux_mode_q <= mcv_pkg::M_CC; prio_q <= mcv_pkg::P_PEDAL;
			retrig_q <= mcv_pkg::RT_NEW; cc_q <= 7'd1;
			vel_q <= 1'b0; vel_val_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(mcv_pkg::REG_LISTEN)) listen_q <= cfg_data;
				else omni_q <= cfg_data[0];
			end
			case (tstate_q)
				T_IDLE: begin
					if (accept) begin
						tstate_q <= T_WAIT;
						vel_q <= cmd.start && cmd.note_on && aux_mode_q == mcv_pkg::M_VEL;
						vel_val_q <= {rx_byte[6:0], 1'b0};
						if (rx_byte > 8'hF7) begin
						end else if (rx_byte > 8'hEF) begin
							status_q <= '0; phase_q <= '0;
						end else if (rx_byte[7]) begin
							status_q <= rx_byte; phase_q <= 2'd1;
						end else if (status_q != 8'd0) begin
							if (phase_q == 2'd1) begin
								first_q <= rx_byte[6:0];
								if (kind == mcv_pkg::K_PROG) begin
									if (ch_ok) begin
										case (rx_byte)
											8'd0: aux_mode_q <= mcv_pkg::M_BEND;
											8'd2: begin aux_mode_q <= mcv_pkg::M_CC; cc_q <= 7'd3; end
											8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8,
											8'd12, 8'd13, 8'd14, 8'd15: aux_mode_q <= rx_byte[3:0];
											8'd9: prio_q <= (prio_q >= mcv_pkg::P_PEDAL) ?
												mcv_pkg::P_RECENT : prio_q + 3'd1;
											8'd10: begin
												if (retrig_q == mcv_pkg::RT_NEW) retrig_q <= mcv_pkg::RT_EVERY;
												else if (retrig_q == mcv_pkg::RT_EVERY) retrig_q <= mcv_pkg::RT_OFF;
												else retrig_q <= mcv_pkg::RT_NEW;
											end
											default: begin aux_mode_q <= mcv_pkg::M_CC; cc_q <= 7'd1; end
										endcase
									end
								end else if (kind != mcv_pkg::K_PRESS) begin
									phase_q <= 2'd2;
								end
							end else if (phase_q == 2'd2) begin
								phase_q <= 2'd1;
								if (ch_ok && kind == mcv_pkg::K_CC && first_q == mcv_pkg::RETRIG_CC) begin
									if (rx_byte > 8'd83) retrig_q <= mcv_pkg::RT_EVERY;
									else if (rx_byte > 8'd42) retrig_q <= mcv_pkg::RT_NEW;
									else retrig_q <= mcv_pkg::RT_OFF;
								end
							end
						end
					end
				end
				T_WAIT: begin
					if (!busy) begin
						tstate_q <= T_OUT;
						vel_q <= 1'b0;
					end
				end
				T_OUT: begin
					if (!out_stall) tstate_q <= T_IDLE;
				end
				default: tstate_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid = (tstate_q == T_OUT);
	assign pitch_level = pitch_q;
	assign aux_level = aux_q;
	assign gate_level = gate_q;
	assign retrigger_pulse = pulse_q;

	`MCV_ASSERT_IMP(a_stall_busy, busy, in_stall)
	`MCV_ASSERT_NEXT(a_accept_wait, accept, tstate_q == T_WAIT)
	`MCV_ASSERT_IMP(a_out_idle, out_valid, !busy)
endmodule

// ===== rtl/mcv_note_engine.sv =====
// Note stack engine: search, insert, remove with shift, and priority scan.
`include "midi_to_cv_note_controller_defines.svh"
module mcv_note_engine #(
	parameter int STACK_DEPTH = mcv_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mcv_pkg::note_cmd_t cmd,
	input  logic [3:0]        aux_mode,
	input  logic [2:0]        priority_mode,
	input  logic [1:0]        retrig_mode,
	input  logic              pitch_set,
	input  logic [7:0]        pitch_val,
	input  logic              aux_set,
	input  logic [7:0]        aux_val,
	input  logic              pulse_clr,
	output logic              busy,
	output logic [7:0]        pitch_q,
	output logic [7:0]        aux_q,
	output logic              gate_q,
	output logic              pulse_q
);
	localparam int IW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_PLAY = 3'd4;

	logic [5:0]    stack_mem [STACK_DEPTH];
	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          on_q;
	logic [5:0]    note_q;
	logic [5:0]    hi_q, lo_q, nw_q, lt_q, pd_q;
	logic [5:0]    rd_data;
	logic [IW-1:0] rd_idx;
	logic [CW-1:0] idx_inc;
	logic [7:0]    p4, a4;
	logic [5:0]    pn, an;
	logic          para;

	assign busy = (state_q != S_IDLE);
	assign rd_idx = idx_q[IW-1:0];
	assign rd_data = stack_mem[rd_idx];
	assign idx_inc = idx_q + CW'(1);

	// Priority selection from the scanned extremes and named slots.
	always_comb begin
		pn = nw_q;
		an = pd_q;
		case (priority_mode)
			mcv_pkg::P_RECENT: begin pn = nw_q; an = lt_q; end
			mcv_pkg::P_RECENT_LOW: begin
				if (nw_q > lt_q) begin pn = nw_q; an = lt_q; end
				else begin pn = lt_q; an = nw_q; end
			end
			mcv_pkg::P_RECENT_HIGH: begin
				if (nw_q > lt_q) begin pn = lt_q; an = nw_q; end
				else begin pn = nw_q; an = lt_q; end
			end
			mcv_pkg::P_OUTER: begin pn = hi_q; an = lo_q; end
			mcv_pkg::P_HIGH: begin
				if (nw_q >= hi_q) begin pn = lt_q; an = nw_q; end
				else begin pn = nw_q; an = hi_q; end
			end
			mcv_pkg::P_LOW: begin
				if (nw_q <= lo_q) begin pn = lt_q; an = nw_q; end
				else begin pn = nw_q; an = lo_q; end
			end
			default: begin pn = nw_q; an = pd_q; end
		endcase
		para = (aux_mode == mcv_pkg::M_PARA) && (count_q > CW'(1));
		if (!para) begin
			pn = nw_q;
			an = nw_q;
		end
		p4 = {pn, 2'b00};
		a4 = {an, 2'b00};
	end

	// Stack storage.
	always_ff @(posedge clk) begin
		if (state_q == S_SRCH && idx_q == count_q && on_q && count_q < DEPTH_C) begin
			stack_mem[rd_idx] <= note_q;
		end else if (state_q == S_SHIFT && idx_inc < count_q) begin
			stack_mem[rd_idx] <= stack_mem[idx_inc[IW-1:0]];
		end
	end

	// Sequencer and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			on_q <= 1'b0;
			note_q <= '0;
			pitch_q <= 8'd0;
			aux_q <= 8'd127;
			gate_q <= 1'b0;
			pulse_q <= 1'b0;
			hi_q <= '0; lo_q <= '0; nw_q <= '0; lt_q <= '0; pd_q <= '0;
		end else begin
			if (pulse_clr) pulse_q <= 1'b0;
			if (pitch_set) pitch_q <= pitch_val;
			if (aux_set) aux_q <= aux_val;
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						on_q <= cmd.note_on;
						note_q <= cmd.note;
						idx_q <= '0;
						if (cmd.note_on || count_q != '0) state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (idx_q < count_q && rd_data == note_q) begin
						if (on_q) begin
							pitch_q <= {note_q, 2'b00};
							if (aux_mode == mcv_pkg::M_NOTE) aux_q <= {note_q, 2'b00};
							if (aux_mode == mcv_pkg::M_INVNOTE)
								aux_q <= mcv_pkg::AUX_TOP - {note_q, 2'b00};
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (idx_q == count_q) begin
						if (on_q && count_q < DEPTH_C) begin
							count_q <= count_q + CW'(1);
							idx_q <= '0;
							hi_q <= '0;
							lo_q <= 6'h3F;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_SHIFT: begin
					if (idx_inc < count_q) begin
						idx_q <= idx_inc;
					end else begin
						count_q <= count_q - CW'(1);
						idx_q <= '0;
						hi_q <= '0;
						lo_q <= 6'h3F;
						if (count_q == CW'(1)) begin
							gate_q <= 1'b0;
							if (aux_mode == mcv_pkg::M_GATE) aux_q <= 8'd0;
							else if (aux_mode == mcv_pkg::M_INVGATE) aux_q <= 8'd255;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// One stack entry per cycle: extremes and the named slots.
					if (rd_data > hi_q) hi_q <= rd_data;
					if (rd_data < lo_q) lo_q <= rd_data;
					if (idx_q == '0) pd_q <= rd_data;
					if (idx_inc == count_q) nw_q <= rd_data;
					if (idx_inc + CW'(1) == count_q) lt_q <= rd_data;
					if (idx_inc == count_q) state_q <= S_PLAY;
					else idx_q <= idx_inc;
				end
				S_PLAY: begin
					pitch_q <= p4;
					if (para) aux_q <= a4;
					else if (aux_mode == mcv_pkg::M_PARA) aux_q <= p4;
					else if (aux_mode == mcv_pkg::M_NOTE) aux_q <= p4;
					else if (aux_mode == mcv_pkg::M_INVNOTE) aux_q <= mcv_pkg::AUX_TOP - p4;
					if (aux_mode == mcv_pkg::M_GATE) aux_q <= 8'd255;
					else if (aux_mode == mcv_pkg::M_INVGATE) aux_q <= 8'd0;
					gate_q <= 1'b1;
					if (on_q ? (retrig_mode != mcv_pkg::RT_OFF)
						: (retrig_mode == mcv_pkg::RT_EVERY)) pulse_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MCV_ASSERT_IMP(a_count_range, 1'b1, count_q <= DEPTH_C)
	`MCV_ASSERT_IMP(a_gate_count, state_q == S_IDLE, gate_q == (count_q != '0))
	`MCV_ASSERT_NEXT(a_play_idle, state_q == S_PLAY, state_q == S_IDLE)
endmodule
